// ----- rtl/pen_tilt_to_lean_azimuth_core_defines.svh -----
// assertion macros shared by the pen tilt converter
`ifndef PEN_TILT_TO_LEAN_AZIMUTH_CORE_DEFINES_SVH
`define PEN_TILT_TO_LEAN_AZIMUTH_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PTLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define PTLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptla_pkg.sv -----
// shared constants, tables and types of the pen tilt converter
package ptla_pkg;

  localparam int CW            = 34;
  localparam int CORDIC_STAGES = 30;
  localparam int FRONT_STAGES  = 4;
  localparam int LATENCY       = FRONT_STAGES + 3 * CORDIC_STAGES + 5;

  localparam int TILT_LIMIT = 8990;
  localparam int DIV_BASE   = 1125;

  localparam logic [29:0] INV_GAIN  = 30'd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // floor(2^59 / 1125) and floor(2^40 / 1125)
  localparam logic [48:0] ANG_RECIP = 49'((64'd1 << 59) / 64'd1125);
  localparam logic [29:0] BAR_RECIP = 30'((64'd1 << 40) / 64'd1125);

  localparam logic [31:0] ATAN [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic        upright;
    logic [15:0] barrel;
  } ptla_tag_t;

endpackage

// ----- rtl/ptla_front.sv -----
// front end: tilt clamp, tilt to angle units, barrel fraction
module ptla_front import ptla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [14:0]   x_tilt_i,
  input  logic signed [14:0]   y_tilt_i,
  input  logic signed [15:0]   barrel_rotation_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_angle_o,
  output logic signed [CW-1:0] y_angle_o,
  output ptla_tag_t            tag_o
);

  logic [FRONT_STAGES-1:0] valid_q;

  // stage 1
  logic signed [14:0] cx, cy;
  logic signed [16:0] bt;
  logic [13:0] mag_x_d, mag_y_d;
  logic [13:0] mag_x_q, mag_y_q;
  logic [3:1]  neg_x_q, neg_y_q, up_q, lo_q, hi_q;
  logic [15:0] bt_q;

  always_comb begin
    cx = x_tilt_i;
    if (x_tilt_i < -15'(TILT_LIMIT)) cx = -15'(TILT_LIMIT);
    else if (x_tilt_i > 15'(TILT_LIMIT)) cx = 15'(TILT_LIMIT);
    cy = y_tilt_i;
    if (y_tilt_i < -15'(TILT_LIMIT)) cy = -15'(TILT_LIMIT);
    else if (y_tilt_i > 15'(TILT_LIMIT)) cy = 15'(TILT_LIMIT);
    mag_x_d = cx[14] ? 14'(-cx) : 14'(cx);
    mag_y_d = cy[14] ? 14'(-cy) : 14'(cy);
    bt      = 17'(barrel_rotation_i) + 17'sd18000;
  end

  // stage 2
  logic [62:0] px, py;
  logic [30:0] q0_x_q, q0_y_q;
  logic [13:0] mag2_x_q, mag2_y_q;
  logic [26:0] nb_q;

  assign px = 63'(mag_x_q) * 63'(ANG_RECIP);
  assign py = 63'(mag_y_q) * 63'(ANG_RECIP);

  // stage 3
  logic [41:0] rx, ry;
  logic [56:0] pb;
  logic [30:0] q_x_q, q_y_q;
  logic [16:0] bq0_q;
  logic [26:0] nb3_q;

  assign rx = {1'b0, mag2_x_q, 27'd0} - 42'(q0_x_q) * 42'(DIV_BASE);
  assign ry = {1'b0, mag2_y_q, 27'd0} - 42'(q0_y_q) * 42'(DIV_BASE);
  assign pb = 57'(nb_q) * 57'(BAR_RECIP);

  // stage 4
  logic [27:0] rb;
  logic [16:0] bq;
  logic signed [CW-1:0] ax, ay;
  logic [15:0] bar;

  always_comb begin
    rb  = 28'(nb3_q) - 28'(bq0_q) * 28'(DIV_BASE);
    bq  = bq0_q + ((rb >= 28'(DIV_BASE)) ? 17'd1 : 17'd0);
    ax  = neg_x_q[3] ? -CW'(q_x_q) : CW'(q_x_q);
    ay  = neg_y_q[3] ? -CW'(q_y_q) : CW'(q_y_q);
    if (lo_q[3])      bar = 16'd0;
    else if (hi_q[3]) bar = 16'hFFFF;
    else              bar = bq[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_q    <= mag_x_d;
    mag_y_q    <= mag_y_d;
    neg_x_q[1] <= cx[14];
    neg_y_q[1] <= cy[14];
    up_q[1]    <= (x_tilt_i == 15'sd0) && (y_tilt_i == 15'sd0);
    lo_q[1]    <= (bt <= 17'sd0);
    hi_q[1]    <= (bt >= 17'sd36000);
    bt_q       <= bt[15:0];

    neg_x_q[3:2] <= neg_x_q[2:1];
    neg_y_q[3:2] <= neg_y_q[2:1];
    up_q[3:2]    <= up_q[2:1];
    lo_q[3:2]    <= lo_q[2:1];
    hi_q[3:2]    <= hi_q[2:1];

    q0_x_q   <= px[62:32];
    q0_y_q   <= py[62:32];
    mag2_x_q <= mag_x_q;
    mag2_y_q <= mag_y_q;
    nb_q     <= 27'((32'(bt_q) * 32'd65535 + 32'd18000) >> 5);

    q_x_q <= q0_x_q + ((rx >= 42'(DIV_BASE)) ? 31'd1 : 31'd0);
    q_y_q <= q0_y_q + ((ry >= 42'(DIV_BASE)) ? 31'd1 : 31'd0);
    bq0_q <= pb[56:40];
    nb3_q <= nb_q;

    x_angle_o      <= ax;
    y_angle_o      <= ay;
    tag_o.upright  <= up_q[3];
    tag_o.barrel   <= bar;
  end

  assign valid_o = valid_q[FRONT_STAGES-1];

endmodule

// ----- rtl/ptla_cordic.sv -----
// unrolled cordic pipeline, one micro-rotation per register stage
module ptla_cordic import ptla_pkg::*; #(
  parameter bit VECTOR = 1'b0,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 valid_q [CORDIC_STAGES];
  logic signed [CW-1:0] x_q [CORDIC_STAGES];
  logic signed [CW-1:0] y_q [CORDIC_STAGES];
  logic signed [CW-1:0] z_q [CORDIC_STAGES];
  logic [SIDE_W-1:0]    side_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [CW-1:0] STEP = CW'(ATAN[i]);
    logic signed [CW-1:0] xs, ys, zs, x_d, y_d, z_d;
    logic [SIDE_W-1:0]    ss;
    logic                 vs, fold;

    if (i == 0) begin : g_head
      assign xs = x_i;
      assign ys = y_i;
      assign zs = z_i;
      assign ss = side_i;
      assign vs = valid_i;
    end else begin : g_body
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign zs = z_q[i-1];
      assign ss = side_q[i-1];
      assign vs = valid_q[i-1];
    end

    // fold: rotate clockwise, angle accumulator goes up
    assign fold = VECTOR ? (ys >= 0) : (zs < 0);

    always_comb begin
      if (fold) begin
        x_d = xs + (ys >>> i);
        y_d = ys - (xs >>> i);
        z_d = zs + STEP;
      end else begin
        x_d = xs - (ys >>> i);
        y_d = ys + (xs >>> i);
        z_d = zs - STEP;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= vs;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i]    <= x_d;
      y_q[i]    <= y_d;
      z_q[i]    <= z_d;
      side_q[i] <= ss;
    end
  end

  assign valid_o = valid_q[CORDIC_STAGES-1];
  assign x_o     = x_q[CORDIC_STAGES-1];
  assign y_o     = y_q[CORDIC_STAGES-1];
  assign z_o     = z_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

// ----- rtl/pen_tilt_to_lean_azimuth_core.sv -----
// top level of the pen tilt to lean / azimuth / barrel converter
//
//   port group        dir  handshake            word
//   sample in         in   start / busy         x_tilt_i, y_tilt_i, barrel_rotation_i
//   result out        out  done_o strobe        lean_o, azimuth_o, barrel_o
//
// a sample can be taken every cycle; busy stays low
// each sample gives one result word; the pipeline runs through
//   4 front stages, three 30-stage cordic pipelines, 5 product and rounding stages
// reset clears only the valid bits along the pipeline
// the result strobe lasts one cycle and is not held off by the receiver
`include "pen_tilt_to_lean_azimuth_core_defines.svh"

module pen_tilt_to_lean_azimuth_core import ptla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [14:0] x_tilt_i,
  input  logic signed [14:0] y_tilt_i,
  input  logic signed [15:0] barrel_rotation_i,
  output logic               done_o,
  output logic [15:0]        lean_o,
  output logic [15:0]        azimuth_o,
  output logic [15:0]        barrel_o
);

  localparam int TAG_W = $bits(ptla_tag_t);

  assign busy = 1'b0;

  // front end
  logic                 fr_valid;
  logic signed [CW-1:0] fr_ax, fr_ay;
  ptla_tag_t            fr_tag;

  ptla_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start),
    .x_tilt_i          (x_tilt_i),
    .y_tilt_i          (y_tilt_i),
    .barrel_rotation_i (barrel_rotation_i),
    .valid_o           (fr_valid),
    .x_angle_o         (fr_ax),
    .y_angle_o         (fr_ay),
    .tag_o             (fr_tag)
  );

  // sine and cosine of both tilts
  logic                 rx_valid;
  logic signed [CW-1:0] cos_x, sin_x, cos_y, sin_y;
  logic [TAG_W-1:0]     rx_side;

  ptla_cordic #(.VECTOR(1'b0), .SIDE_W(TAG_W)) u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .x_i     (CW'(INV_GAIN)),
    .y_i     ('0),
    .z_i     (fr_ax),
    .side_i  (fr_tag),
    .valid_o (rx_valid),
    .x_o     (cos_x),
    .y_o     (sin_x),
    .z_o     (),
    .side_o  (rx_side)
  );

  ptla_cordic #(.VECTOR(1'b0), .SIDE_W(1)) u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .x_i     (CW'(INV_GAIN)),
    .y_i     ('0),
    .z_i     (fr_ay),
    .side_i  (1'b0),
    .valid_o (),
    .x_o     (cos_y),
    .y_o     (sin_y),
    .z_o     (),
    .side_o  ()
  );

  // products u, v, p in q30
  logic signed [63:0] pu, pv, pp;
  logic               p1_valid_q, p2_valid_q;
  logic signed [CW-1:0] u_q, v_q, p_q, u2_q, v2_q, p2_q, az0_q;
  ptla_tag_t          p1_tag_q, p2_tag_q;

  assign pu = $signed(sin_x[31:0]) * $signed(cos_y[31:0]);
  assign pv = $signed(sin_y[31:0]) * $signed(cos_x[31:0]);
  assign pp = $signed(cos_x[31:0]) * $signed(cos_y[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= rx_valid;
      p2_valid_q <= p1_valid_q;
    end
  end

  // register the products, then fold the left half-plane onto the right
  always_ff @(posedge clk_i) begin
    u_q      <= pu[63:30];
    v_q      <= pv[63:30];
    p_q      <= pp[63:30];
    p1_tag_q <= rx_side;
    u2_q     <= u_q[CW-1] ? -u_q : u_q;
    v2_q     <= u_q[CW-1] ? -v_q : v_q;
    az0_q    <= u_q[CW-1] ? CW'(HALF_TURN) : '0;
    p2_q     <= p_q;
    p2_tag_q <= p1_tag_q;
  end

  // azimuth vectoring, carries p along
  logic                    va_valid;
  logic signed [CW-1:0]    va_x, va_z;
  logic [CW+TAG_W-1:0]     va_side;
  logic signed [CW-1:0]    va_p;
  ptla_tag_t               va_tag;

  ptla_cordic #(.VECTOR(1'b1), .SIDE_W(CW + TAG_W)) u_vec_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_valid_q),
    .x_i     (u2_q),
    .y_i     (v2_q),
    .z_i     (az0_q),
    .side_i  ({p2_q, p2_tag_q}),
    .valid_o (va_valid),
    .x_o     (va_x),
    .y_o     (),
    .z_o     (va_z),
    .side_o  (va_side)
  );

  assign va_p   = va_side[CW+TAG_W-1:TAG_W];
  assign va_tag = va_side[TAG_W-1:0];

  // magnitude with gain removed
  logic signed [67:0]   pm;
  logic                 m_valid_q;
  logic signed [CW-1:0] m_q, mp_q;
  logic [31:0]          maz_q;
  ptla_tag_t            m_tag_q;

  assign pm = va_x * $signed(CW'(INV_GAIN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= va_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= pm[63:30];
    mp_q    <= va_p;
    maz_q   <= va_z[31:0];
    m_tag_q <= va_tag;
  end

  // lean vectoring, carries azimuth along
  logic                 vl_valid;
  logic signed [CW-1:0] vl_z;
  logic [32+TAG_W-1:0]  vl_side;

  ptla_cordic #(.VECTOR(1'b1), .SIDE_W(32 + TAG_W)) u_vec_lean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid_q),
    .x_i     (mp_q),
    .y_i     (m_q),
    .z_i     ('0),
    .side_i  ({maz_q, m_tag_q}),
    .valid_o (vl_valid),
    .x_o     (),
    .y_o     (),
    .z_o     (vl_z),
    .side_o  (vl_side)
  );

  // scale to 16-bit fractions
  logic signed [31:0] la;
  logic [31:0]        az_f;
  ptla_tag_t          f_tag;
  logic               f1_valid_q, f_pos_q;
  logic [47:0]        lp_q, azp_q;
  ptla_tag_t          f1_tag_q;
  logic [17:0]        lq;

  assign la    = vl_z[31:0];
  assign az_f  = vl_side[32+TAG_W-1:TAG_W];
  assign f_tag = vl_side[TAG_W-1:0];
  assign lq    = lp_q[47:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      f1_valid_q <= vl_valid;
      done_o     <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_pos_q   <= (la > 32'sd0);
    lp_q      <= 48'(la[30:0]) * 48'd65535 + 48'h2000_0000;
    azp_q     <= 48'(az_f) * 48'd65535 + 48'h8000_0000;
    f1_tag_q  <= f_tag;
    lean_o    <= !f_pos_q ? 16'd0 : ((lq > 18'd65535) ? 16'hFFFF : lq[15:0]);
    azimuth_o <= f1_tag_q.upright ? 16'd0 : azp_q[47:32];
    barrel_o  <= f1_tag_q.barrel;
  end

  `PTLA_ASSERT_IMP(a_latency, done_o, $past(start, LATENCY), "result word without a sample")
  `PTLA_ASSERT_IMP(a_upright,
    done_o && $past(start && (x_tilt_i == 15'sd0) && (y_tilt_i == 15'sd0), LATENCY),
    azimuth_o == 16'd0, "upright pen gave nonzero azimuth")
  `PTLA_ASSERT_IMP(a_barrel_hi,
    done_o && $past(start && (barrel_rotation_i >= 16'sd18000), LATENCY),
    barrel_o == 16'hFFFF, "barrel did not saturate high")

endmodule
